>>> rtl/bspline_de_boor_point_evaluator_top_macros.svh
// Assertion macros shared by the checker of the de Boor point evaluator.
`ifndef BSPLINE_DE_BOOR_POINT_EVALUATOR_TOP_MACROS_SVH
`define BSPLINE_DE_BOOR_POINT_EVALUATOR_TOP_MACROS_SVH

// Same-cycle implication, held off during reset.
`define BSPDE_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bspde check failed");

// Next-cycle implication, held off during reset.
`define BSPDE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bspde check failed");

// Next-cycle implication that also covers the reset cycles.
`define BSPDE_ASSERT_RESET_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bspde check failed");

`endif

>>> rtl/bspde_pkg.sv
// Types and constants of the de Boor point evaluator.
`default_nettype none

package bspde_pkg;

  localparam int unsigned ORDER    = 3;
  localparam int unsigned COORD_W  = 10;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned RES_W    = 18;

  localparam int unsigned FRAC_ONE = 1 << FRAC_W;
  // common denominator of the first level: (ORDER - 1) in knot units
  localparam int unsigned DEN1     = (ORDER - 1) * FRAC_ONE;
  localparam int unsigned WEIGHT_W = $clog2(DEN1) + 1;
  localparam int unsigned L1_W     = COORD_W + WEIGHT_W - 1;
  localparam int unsigned L2_W     = L1_W + FRAC_W;
  // total scale is DEN1 * FRAC_ONE; the Q.8 result drops all but FRAC_W of it
  localparam int unsigned ROUND_SHIFT = L2_W - RES_W;
  localparam int unsigned ROUND_BIAS  = 1 << (ROUND_SHIFT - 1);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_t;

  typedef struct packed {
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } point_t;

  typedef struct packed {
    logic              ok;
    logic              err;
    logic [FRAC_W-1:0] frac;
  } meta_t;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

endpackage

`default_nettype wire

>>> rtl/bspde_item_if.sv
// Input channel: control point writes and evaluate requests.
`default_nettype none

interface bspde_item_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [bspde_pkg::IDX_W-1:0]   point_index;
  logic [bspde_pkg::COORD_W-1:0] point_x;
  logic [bspde_pkg::COORD_W-1:0] point_y;
  logic [bspde_pkg::IDX_W-1:0]   span;
  logic [bspde_pkg::FRAC_W-1:0]  fraction;

  modport source (
    output valid, operation, point_index, point_x, point_y, span, fraction,
    input  ready
  );
  modport sink (
    input  valid, operation, point_index, point_x, point_y, span, fraction,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/bspde_result_if.sv
// Output channel: evaluated curve points.
`default_nettype none

interface bspde_result_if;
  logic                        valid;
  logic                        ready;
  logic [bspde_pkg::RES_W-1:0] curve_x;
  logic [bspde_pkg::RES_W-1:0] curve_y;
  logic                        span_error;

  modport source (
    output valid, curve_x, curve_y, span_error,
    input  ready
  );
  modport sink (
    input  valid, curve_x, curve_y, span_error,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/bspde_ram.sv
// Generic synchronous RAM: one write port, one or more registered read ports.
`default_nettype none

module bspde_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned READS = 2,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr [READS],
  output logic      [WIDTH-1:0]  rdata [READS]
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data between reads
    if (re) begin
      for (int i = 0; i < READS; i++) begin
        rdata[i] <= mem[raddr[i]];
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/bspde_lane.sv
// One coordinate of the quadratic de Boor triangle, four register stages.
`default_nettype none

module bspde_lane (
  input  wire logic                          clk,
  input  wire bspde_pkg::stage_en_t          en,
  input  wire logic [bspde_pkg::FRAC_W-1:0]  frac_s1,
  input  wire logic [bspde_pkg::FRAC_W-1:0]  frac_s3,
  input  wire logic [bspde_pkg::COORD_W-1:0] tap [bspde_pkg::ORDER],
  output logic      [bspde_pkg::RES_W-1:0]   value
);

  localparam int unsigned WW = bspde_pkg::WEIGHT_W;
  localparam int unsigned W1 = bspde_pkg::L1_W;
  localparam int unsigned W2 = bspde_pkg::L2_W;

  // first level weights, in units of 1/256 knot
  logic [WW-1:0] w_far_left;
  logic [WW-1:0] w_near_left;
  logic [WW-1:0] w_near_right;
  logic [WW-1:0] w_frac;
  logic [W1-1:0] prod_a, prod_b, prod_c, prod_d;
  logic [W1-1:0] prod_a_next, prod_b_next, prod_c_next, prod_d_next;
  logic [W1-1:0] lvl1_hi, lvl1_lo;
  logic [WW-1:0] w2_left;
  logic [W2-1:0] prod_e, prod_f;
  logic [W2-1:0] prod_e_next, prod_f_next;
  logic [W2-1:0] total;

  assign w_frac       = WW'(frac_s1);
  assign w_far_left   = WW'(bspde_pkg::DEN1) - w_frac;
  assign w_near_left  = WW'(bspde_pkg::FRAC_ONE) - w_frac;
  assign w_near_right = WW'(bspde_pkg::FRAC_ONE) + w_frac;

  assign prod_a_next = W1'(w_far_left)   * W1'(tap[1]);
  assign prod_b_next = W1'(w_frac)       * W1'(tap[2]);
  assign prod_c_next = W1'(w_near_left)  * W1'(tap[0]);
  assign prod_d_next = W1'(w_near_right) * W1'(tap[1]);

  assign w2_left     = WW'(bspde_pkg::FRAC_ONE) - WW'(frac_s3);
  assign prod_e_next = W2'(w2_left) * W2'(lvl1_lo);
  assign prod_f_next = W2'(frac_s3) * W2'(lvl1_hi);

  assign total = prod_e + prod_f + W2'(bspde_pkg::ROUND_BIAS);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      prod_a <= prod_a_next;
      prod_b <= prod_b_next;
      prod_c <= prod_c_next;
      prod_d <= prod_d_next;
    end
    if (en.s3) begin
      lvl1_hi <= prod_a + prod_b;
      lvl1_lo <= prod_c + prod_d;
    end
    if (en.s4) begin
      prod_e <= prod_e_next;
      prod_f <= prod_f_next;
    end
    // round half up to Q10.8
    if (en.s5) begin
      value <= total[W2-1:bspde_pkg::ROUND_SHIFT];
    end
  end

endmodule

`default_nettype wire

>>> rtl/bspline_de_boor_point_evaluator_top.sv
// Top level of the quadratic B-spline de Boor point evaluator.
// Stages: table read, first products, first sums, second products, rounding.
// Throughput: one item per cycle unless stalled; the three neighbouring control
//   points are read together from two table copies, one with two read ports.
// Reset clears the pipeline and points_in_use; the point table is not cleared.
`default_nettype none

module bspline_de_boor_point_evaluator_top #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [bspde_pkg::COUNT_W-1:0] cfg_wr_data,
  bspde_item_if.sink                         item,
  bspde_result_if.source                     result
);

  localparam int unsigned ORDER  = bspde_pkg::ORDER;
  localparam int unsigned ADDR_W = $clog2(MAX_POINTS);
  localparam int unsigned NCOPY  = (ORDER + 1) / 2;
  localparam int unsigned PT_W   = $bits(bspde_pkg::point_t);

  logic [bspde_pkg::COUNT_W-1:0] points_in_use;

  logic v1, v2, v3, v4, v5;
  logic free1, free2, free3, free4, free5;
  bspde_pkg::meta_t     m1, m2, m3, m4, m5;
  bspde_pkg::meta_t     meta_in;
  bspde_pkg::stage_en_t lane_en;

  logic accept;
  logic is_eval;
  logic span_bad;
  logic wr_en;
  logic rd_en;
  logic [ADDR_W-1:0]      wr_addr;
  bspde_pkg::point_t      wr_point;
  bspde_pkg::point_t      tap_pt [ORDER];
  logic [bspde_pkg::COORD_W-1:0] tap_x [ORDER];
  logic [bspde_pkg::COORD_W-1:0] tap_y [ORDER];
  logic [bspde_pkg::RES_W-1:0]   val_x, val_y;

  // stall chain: a stage loads when it is empty or its content moves on
  assign free5 = !v5 || result.ready;
  assign free4 = !v4 || free5;
  assign free3 = !v3 || free4;
  assign free2 = !v2 || free3;
  assign free1 = !v1 || free2;

  assign item.ready = free1;
  assign accept     = item.valid && free1;
  assign is_eval    = (item.operation == bspde_pkg::OP_EVAL);

  assign span_bad = (item.span < bspde_pkg::IDX_W'(ORDER - 1))
                 || ({1'b0, item.span} >= points_in_use)
                 || (32'(item.span) >= MAX_POINTS);

  assign meta_in.ok   = is_eval && !span_bad;
  assign meta_in.err  = is_eval && span_bad;
  assign meta_in.frac = item.fraction;

  assign wr_en    = accept && !is_eval && (32'(item.point_index) < MAX_POINTS);
  assign rd_en    = accept && is_eval && !span_bad;
  assign wr_addr  = ADDR_W'(item.point_index);
  assign wr_point = '{y: item.point_y, x: item.point_x};

  // tap m sits in table copy m/2, read port m%2
  for (genvar c = 0; c < NCOPY; c++) begin : g_copy
    localparam int unsigned NREAD = (ORDER - 2 * c >= 2) ? 2 : 1;
    logic [ADDR_W-1:0] raddr [NREAD];
    logic [PT_W-1:0]   rdata [NREAD];

    for (genvar k = 0; k < NREAD; k++) begin : g_port
      assign raddr[k] = ADDR_W'(item.span) - ADDR_W'(ORDER - 1 - (2 * c + k));
      assign tap_pt[2 * c + k] = bspde_pkg::point_t'(rdata[k]);
    end

    bspde_ram #(
      .WIDTH (PT_W),
      .DEPTH (MAX_POINTS),
      .READS (NREAD)
    ) u_table (
      .clk   (clk),
      .we    (wr_en),
      .waddr (wr_addr),
      .wdata (wr_point),
      .re    (rd_en),
      .raddr (raddr),
      .rdata (rdata)
    );
  end

  for (genvar m = 0; m < ORDER; m++) begin : g_tap
    assign tap_x[m] = tap_pt[m].x;
    assign tap_y[m] = tap_pt[m].y;
  end

  assign lane_en.s2 = free2 && v1;
  assign lane_en.s3 = free3 && v2;
  assign lane_en.s4 = free4 && v3;
  assign lane_en.s5 = free5 && v4;

  bspde_lane u_lane_x (
    .clk     (clk),
    .en      (lane_en),
    .frac_s1 (m1.frac),
    .frac_s3 (m3.frac),
    .tap     (tap_x),
    .value   (val_x)
  );

  bspde_lane u_lane_y (
    .clk     (clk),
    .en      (lane_en),
    .frac_s1 (m1.frac),
    .frac_s3 (m3.frac),
    .tap     (tap_y),
    .value   (val_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        points_in_use <= cfg_wr_data;
      end
      if (free1) v1 <= item.valid;
      if (free2) v2 <= v1;
      if (free3) v3 <= v2;
      if (free4) v4 <= v3;
      if (free5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (accept)     m1 <= meta_in;
    if (lane_en.s2) m2 <= m1;
    if (lane_en.s3) m3 <= m2;
    if (lane_en.s4) m4 <= m3;
    if (lane_en.s5) m5 <= m4;
  end

  // writes and rejected spans leave zeros on the coordinates
  assign result.valid      = v5;
  assign result.curve_x    = m5.ok ? val_x : '0;
  assign result.curve_y    = m5.ok ? val_y : '0;
  assign result.span_error = m5.err;

endmodule

`default_nettype wire

>>> rtl/bspde_checker.sv
// Port-level checks of the de Boor point evaluator, bound to the top level.
`default_nettype none

`include "bspline_de_boor_point_evaluator_top_macros.svh"

module bspde_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        item_valid,
  input wire logic                        item_ready,
  input wire logic                        result_valid,
  input wire logic                        result_ready,
  input wire logic [bspde_pkg::RES_W-1:0] curve_x,
  input wire logic [bspde_pkg::RES_W-1:0] curve_y,
  input wire logic                        span_error
);

  localparam int unsigned DEPTH = 5;

  logic [2:0] inflight;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = item_valid && item_ready;
  assign out_xfer = result_valid && result_ready;

  // count items taken in whose result has not been transferred yet
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + 3'(in_xfer) - 3'(out_xfer);
    end
  end

  `BSPDE_ASSERT_RESET_NEXT(a_reset_empty, rst, !result_valid)
  `BSPDE_ASSERT_IMPLY(a_result_has_item, result_valid, inflight != 3'd0)
  `BSPDE_ASSERT_IMPLY(a_depth_bound, 1'b1, inflight <= 3'(DEPTH))
  `BSPDE_ASSERT_IMPLY(a_error_zero, result_valid && span_error, (curve_x == '0) && (curve_y == '0))
  `BSPDE_ASSERT_NEXT(a_stall_hold, result_valid && !result_ready, result_valid && $stable(curve_x) && $stable(curve_y) && $stable(span_error))

endmodule

bind bspline_de_boor_point_evaluator_top bspde_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .curve_x      (result.curve_x),
  .curve_y      (result.curve_y),
  .span_error   (result.span_error)
);

`default_nettype wire

>>> test/tb_bspline_de_boor_point_evaluator_top.sv
// Self-checking testbench of the quadratic B-spline de Boor point evaluator.
`timescale 1ns / 100ps

module tb_bspline_de_boor_point_evaluator_top;
  import bspde_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 256;
  localparam int unsigned PIPE_LATENCY = 5;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned RUN_LIMIT    = 400000;
  localparam longint unsigned BLEND_SCALE = longint'(DEN1) * FRAC_ONE;

  typedef struct packed {
    op_t                operation;
    logic [IDX_W-1:0]   point_index;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [IDX_W-1:0]   span;
    logic [FRAC_W-1:0]  fraction;
  } spline_req_t;

  typedef struct packed {
    logic [RES_W-1:0] x;
    logic [RES_W-1:0] y;
    logic             err;
  } curve_pt_t;

  class curve_point_scoreboard;
    point_t      pts[TABLE_DEPTH];
    bit          filled[TABLE_DEPTH];
    int unsigned point_count;
    curve_pt_t   expected_points[$];
    int unsigned mismatches, writes, evaluations, span_errors;

    function void set_point_count(int unsigned n);
      point_count = n;
    endfunction

    function int unsigned usable_count();
      return (point_count > TABLE_DEPTH) ? TABLE_DEPTH : point_count;
    endfunction

    function bit span_in_range(int unsigned s);
      return (s >= ORDER - 1) && (s < usable_count());
    endfunction

    function bit span_filled(int unsigned s);
      for (int k = s - (ORDER - 1); k <= s; k++)
        if (!filled[k]) return 1'b0;
      return 1'b1;
    endfunction

    // Two blend levels over the neighbours s-2, s-1, s, kept exact on a common denominator.
    function logic [RES_W-1:0] de_boor_coord(int unsigned s, logic [FRAC_W-1:0] f, bit on_y);
      longint unsigned c[3];
      longint unsigned ff, left, right, top;
      ff = f;
      for (int m = 0; m < 3; m++)
        c[m] = on_y ? pts[s - 2 + m].y : pts[s - 2 + m].x;
      left  = (FRAC_ONE - ff) * c[0] + (FRAC_ONE + ff) * c[1];
      right = (DEN1 - ff) * c[1] + ff * c[2];
      top   = (FRAC_ONE - ff) * left + ff * right;
      return RES_W'((top * FRAC_ONE + BLEND_SCALE / 2) / BLEND_SCALE);
    endfunction

    function void note_item(spline_req_t r);
      curve_pt_t e;
      e = '0;
      if (r.operation == OP_WRITE) begin
        pts[r.point_index].x = r.px;
        pts[r.point_index].y = r.py;
        filled[r.point_index] = 1'b1;
        writes++;
      end else if (!span_in_range(r.span)) begin
        e.err = 1'b1;
        span_errors++;
      end else begin
        e.x = de_boor_coord(r.span, r.fraction, 1'b0);
        e.y = de_boor_coord(r.span, r.fraction, 1'b1);
        evaluations++;
      end
      expected_points = {expected_points, e};
    endfunction

    function void check_result(logic [RES_W-1:0] x, logic [RES_W-1:0] y, logic err);
      curve_pt_t e;
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result x=%0h y=%0h err=%0b arrived with nothing pending", x, y, err);
        return;
      end
      e = expected_points.pop_front();
      if (x !== e.x || y !== e.y || err !== e.err) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected x=%0h y=%0h err=%0b, got x=%0h y=%0h err=%0b",
                   e.x, e.y, e.err, x, y, err);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [COUNT_W-1:0] cfg_wr_data;
  logic hold_req;

  bspde_item_if   item_ch ();
  bspde_result_if result_ch ();

  bspline_de_boor_point_evaluator_top #(
    .MAX_POINTS (TABLE_DEPTH)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item_ch),
    .result      (result_ch)
  );

  curve_point_scoreboard scoreboard = new();

  int unsigned cycle_count;
  int unsigned burst_left, items_sent, settings_used;
  bit          steady_sender;
  int unsigned hold_left, holds_done, stall_mode, mode_left, stall_tick;

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               scoreboard.expected_points.size());
      $display("status: fail");
      $finish;
    end
  end

  // Check each result transfer, then pick the next ready value.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready)
        scoreboard.check_result(result_ch.curve_x, result_ch.curve_y, result_ch.span_error);
      if (hold_left != 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req <= 1'b0;
        hold_left = HOLD_CYCLES - 1;
        holds_done++;
        result_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(20, 200);
        end
        mode_left--;
        stall_tick++;
        case (stall_mode)
          0: result_ch.ready <= 1'b1;
          1: result_ch.ready <= 1'($urandom_range(0, 1));
          2: result_ch.ready <= (stall_tick % 4) == 0;
          default: result_ch.ready <= (stall_tick % 8) >= 3;
        endcase
      end
    end
  end

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic logic [FRAC_W-1:0] rand_frac();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return FRAC_W'(FRAC_ONE / 2);
      default: return FRAC_W'($urandom);
    endcase
  endfunction

  // Unused fields carry random values so the block is seen to ignore them.
  function automatic spline_req_t req_write(int unsigned idx, logic [COORD_W-1:0] x,
                                            logic [COORD_W-1:0] y);
    spline_req_t r;
    r = spline_req_t'({$urandom, $urandom});
    r.operation   = OP_WRITE;
    r.point_index = IDX_W'(idx);
    r.px          = x;
    r.py          = y;
    return r;
  endfunction

  function automatic spline_req_t req_eval(int unsigned s, logic [FRAC_W-1:0] f);
    spline_req_t r;
    r = spline_req_t'({$urandom, $urandom});
    r.operation = OP_EVAL;
    r.span      = IDX_W'(s);
    r.fraction  = f;
    return r;
  endfunction

  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      item_ch.valid       <= 1'b0;
      item_ch.operation   <= 1'($urandom_range(0, 1));
      item_ch.point_index <= IDX_W'($urandom);
      item_ch.point_x     <= COORD_W'($urandom);
      item_ch.point_y     <= COORD_W'($urandom);
      item_ch.span        <= IDX_W'($urandom);
      item_ch.fraction    <= FRAC_W'($urandom);
      @(posedge clk);
    end
  endtask

  task automatic send_item(spline_req_t r);
    if (burst_left == 0) begin
      if (!steady_sender)
        idle_cycles(($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 6));
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    item_ch.valid       <= 1'b1;
    item_ch.operation   <= r.operation;
    item_ch.point_index <= r.point_index;
    item_ch.point_x     <= r.px;
    item_ch.point_y     <= r.py;
    item_ch.span        <= r.span;
    item_ch.fraction    <= r.fraction;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    scoreboard.note_item(r);
    items_sent++;
  endtask

  // Hold the input until every expected point has come back and the pipeline is empty.
  task automatic drain();
    item_ch.valid <= 1'b0;
    while (scoreboard.expected_points.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 3) @(posedge clk);
  endtask

  task automatic set_point_count(int unsigned n);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= COUNT_W'(n);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    scoreboard.set_point_count(n);
    settings_used++;
  endtask

  task automatic run_directed();
    // no span is valid with a count of zero
    send_item(req_eval(0, 0));
    send_item(req_eval(2, 128));
    send_item(req_eval(255, 255));
    send_item(req_write(0, 0, 0));
    send_item(req_write(1, 1023, 1023));
    send_item(req_write(2, 1023, 0));
    send_item(req_write(3, 0, 1023));
    send_item(req_write(253, 1023, 1023));
    send_item(req_write(254, 512, 1));
    send_item(req_write(255, 1, 512));
    send_item(req_eval(2, 0));
    set_point_count(TABLE_DEPTH);
    send_item(req_eval(2, 0));
    send_item(req_eval(2, 255));
    send_item(req_eval(2, 128));
    send_item(req_eval(3, 1));
    send_item(req_eval(3, 255));
    send_item(req_eval(255, 0));
    send_item(req_eval(255, 255));
    send_item(req_eval(1, 77));
    send_item(req_eval(0, 255));
    // overwrite a slot and read it straight back
    send_item(req_write(2, 0, 1023));
    send_item(req_eval(2, 64));
  endtask

  task automatic run_random(int unsigned n);
    int unsigned goal, pick, count, s;
    goal = items_sent + n;
    while (items_sent < goal) begin
      pick  = $urandom_range(0, 99);
      count = scoreboard.usable_count();
      if (pick < 15) begin
        send_item(req_write($urandom_range(0, TABLE_DEPTH - 1), rand_coord(), rand_coord()));
      end else if (pick < 27 || count < ORDER) begin
        // any span, steered out of range where its neighbours were never written
        s = $urandom_range(0, 255);
        if (scoreboard.span_in_range(s) && !scoreboard.span_filled(s))
          s = (count < TABLE_DEPTH && $urandom_range(0, 1)) ? $urandom_range(count, 255)
                                                          : $urandom_range(0, ORDER - 2);
        send_item(req_eval(s, rand_frac()));
      end else begin
        if (pick < 35)
          s = pick[0] ? ORDER - 1 : count - 1;
        else
          s = $urandom_range(ORDER - 1, count - 1);
        for (int k = s - (ORDER - 1); k <= s; k++)
          if (!scoreboard.filled[k] || $urandom_range(0, 7) == 0)
            send_item(req_write(k, rand_coord(), rand_coord()));
        send_item(req_eval(s, rand_frac()));
      end
    end
  endtask

  initial begin
    rst                 <= 1'b1;
    cfg_wr_en           <= 1'b0;
    cfg_wr_data         <= '0;
    hold_req            <= 1'b0;
    item_ch.valid       <= 1'b0;
    item_ch.operation   <= OP_WRITE;
    item_ch.point_index <= '0;
    item_ch.point_x     <= '0;
    item_ch.point_y     <= '0;
    item_ch.span        <= '0;
    item_ch.fraction    <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_point_count(0);
    run_directed();

    // stall the output for a long stretch while items keep coming
    set_point_count(TABLE_DEPTH);
    hold_req <= 1'b1;
    run_random(260);

    set_point_count(ORDER);
    run_random(220);

    set_point_count(ORDER - 1);
    run_random(150);

    set_point_count($urandom_range(ORDER + 1, TABLE_DEPTH - 1));
    run_random(110);
    drain();
    run_random(110);

    set_point_count(1);
    run_random(120);

    steady_sender = 1'b1;
    set_point_count(TABLE_DEPTH);
    run_random(260);
    steady_sender = 1'b0;

    set_point_count($urandom_range(TABLE_DEPTH / 2, TABLE_DEPTH - 1));
    run_random(220);

    drain();
    repeat (20) @(posedge clk);

    $display("covered %0d point writes, %0d curve evaluations, %0d out-of-range spans",
             scoreboard.writes, scoreboard.evaluations, scoreboard.span_errors);
    $display("over %0d point-count settings and %0d output hold-offs in %0d cycles",
             settings_used, holds_done, cycle_count);
    if (scoreboard.mismatches == 0 && scoreboard.expected_points.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results never arrived", scoreboard.mismatches,
               scoreboard.expected_points.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
